>>> hw/rtl/mtt_pkg.sv
`timescale 1ns / 1ps
// Package for the touch tracker: sizes, types and sequencer states.
package mtt_pkg;
    localparam int MAX_FINGERS = 5;
    localparam int POS_BITS    = 16;
    localparam int CNT_BITS    = 3;
    localparam int IDX_BITS    = 3;
    localparam int PAIR_BITS   = 5;
    localparam int NUM_PAIRS   = MAX_FINGERS * MAX_FINGERS;

    typedef logic [POS_BITS-1:0]  pos_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;
    typedef logic [IDX_BITS-1:0]  idx_t;
    typedef logic [PAIR_BITS-1:0] pair_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST,
        ST_SORT,
        ST_MATCH,
        ST_FILL,
        ST_GAP,
        ST_PLACE,
        ST_DONE
    } state_t;

    // Shared distance unit: request.
    typedef struct packed {
        pos_t a;
        pos_t b;
    } dist_req_t;
endpackage

>>> hw/rtl/mtt_dist_unit.sv
`timescale 1ns / 1ps
// Shared absolute-difference and compare unit used by the sequencer.
module mtt_dist_unit (
    input  mtt_pkg::dist_req_t req,
    input  mtt_pkg::pos_t      cmp_x,
    input  mtt_pkg::pos_t      cmp_y,
    output mtt_pkg::pos_t      abs_diff,
    output logic               x_lt_y
);
    import mtt_pkg::*;

    // Subtract the smaller from the larger
    assign abs_diff = (req.a > req.b) ? pos_t'(req.a - req.b) : pos_t'(req.b - req.a);
    assign x_lt_y   = cmp_x < cmp_y;
endmodule

>>> hw/rtl/mtt_core.sv
`timescale 1ns / 1ps
// Sequencer: builds distances, sorts them one step a cycle, matches and places.
module mtt_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  mtt_pkg::cnt_t       n_in,
    input  mtt_pkg::pos_t       raw_in [mtt_pkg::MAX_FINGERS],
    output logic                done,
    output mtt_pkg::pos_t       stored_out [mtt_pkg::MAX_FINGERS],
    output mtt_pkg::pos_t       newest_pos_out,
    output logic [3:0]          newest_idx_out,
    output mtt_pkg::cnt_t       n_out
);
    import mtt_pkg::*;

    state_t state_reg, state_next;

    cnt_t  prior_reg;
    cnt_t  n_reg;
    pos_t  raw_reg [MAX_FINGERS];
    pos_t  stored_reg [MAX_FINGERS];
    idx_t  slot_reg [MAX_FINGERS];
    pos_t  dist_reg [NUM_PAIRS];
    pair_t pid_reg [NUM_PAIRS];
    logic [MAX_FINGERS-1:0] cur_done_reg, prev_done_reg;
    idx_t  taken_reg;
    logic [3:0] newest_idx_reg;
    pos_t  newest_pos_reg;
    logic  changed_reg;

    // Loop counters
    pair_t m_reg;           // pairs built so far
    pair_t k_reg;           // sort / match position
    idx_t  i_reg, q_reg;    // current / stored index
    idx_t  g_reg;           // gap scan

    dist_req_t req;
    pos_t      dist_w;
    logic      lt_w;
    pos_t      cx, cy;

    // Clamp the incoming count to the number of tracked fingers
    cnt_t n_sat;
    assign n_sat = (n_in > cnt_t'(MAX_FINGERS)) ? cnt_t'(MAX_FINGERS) : n_in;

    mtt_dist_unit u_dist (
        .req     (req),
        .cmp_x   (cx),
        .cmp_y   (cy),
        .abs_diff(dist_w),
        .x_lt_y  (lt_w)
    );

    pair_t k_m1;
    assign k_m1 = k_reg - pair_t'(1);

    always_comb begin
        req.a = raw_reg[i_reg];
        req.b = stored_reg[q_reg];
        cx    = dist_reg[k_reg];
        cy    = dist_reg[k_m1];
    end

    // Pair decode for greedy match
    idx_t pc, ps;
    always_comb begin
        pc = '0;
        ps = '0;
        for (int c = 0; c < MAX_FINGERS; c++) begin
            for (int s = 0; s < MAX_FINGERS; s++) begin
                if (c * int'(prior_reg) + s == int'(pid_reg[k_reg]) && s < int'(prior_reg)) begin
                    pc = idx_t'(c);
                    ps = idx_t'(s);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        done = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    if (n_sat == '0) state_next = ST_DONE;
                    else if (n_sat == prior_reg) state_next = ST_PLACE;
                    else if (prior_reg == '0) state_next = ST_FILL;
                    else state_next = ST_DIST;
                end
            end
            ST_DIST: state_next = ST_SORT;
            ST_SORT: begin
                if (k_reg == '0 || !lt_w) begin
                    if (i_reg == idx_t'(n_reg - 1) && q_reg == idx_t'(prior_reg - 1))
                        state_next = ST_MATCH;
                    else
                        state_next = ST_DIST;
                end
            end
            ST_MATCH: if (k_reg == m_reg - pair_t'(1)) state_next = (prior_reg < n_reg) ? ST_FILL : ST_GAP;
            ST_FILL: if (i_reg == idx_t'(n_reg - 1)) state_next = ST_PLACE;
            ST_GAP: if (g_reg == idx_t'(1)) state_next = ST_PLACE;
            ST_PLACE: state_next = ST_DONE;
            ST_DONE: begin
                done = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prior_reg      <= '0;
            newest_idx_reg <= 4'hF;
            newest_pos_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        for (int j = 0; j < MAX_FINGERS; j++) raw_reg[j] <= raw_in[j];
                        n_reg <= n_sat;
                        changed_reg <= (n_sat != prior_reg);
                        cur_done_reg  <= '0;
                        prev_done_reg <= '0;
                        taken_reg <= '0;
                        m_reg <= '0;
                        i_reg <= '0;
                        q_reg <= '0;
                        g_reg <= idx_t'(prior_reg);
                    end
                end
                ST_DIST: begin
                    dist_reg[m_reg] <= dist_w;
                    pid_reg[m_reg]  <= m_reg;
                    k_reg <= m_reg;
                    m_reg <= m_reg + pair_t'(1);
                end
                ST_SORT: begin
                    if (k_reg != '0 && lt_w) begin
                        dist_reg[k_reg] <= dist_reg[k_m1];
                        dist_reg[k_m1]  <= dist_reg[k_reg];
                        pid_reg[k_reg]  <= pid_reg[k_m1];
                        pid_reg[k_m1]   <= pid_reg[k_reg];
                        k_reg <= k_m1;
                    end else if (q_reg == idx_t'(prior_reg - 1)) begin
                        q_reg <= '0;
                        if (i_reg == idx_t'(n_reg - 1)) begin
                            k_reg <= '0;
                            i_reg <= '0;
                        end else begin
                            i_reg <= i_reg + idx_t'(1);
                        end
                    end else begin
                        q_reg <= q_reg + idx_t'(1);
                    end
                end
                ST_MATCH: begin
                    if (!cur_done_reg[pc] && !prev_done_reg[ps]) begin
                        cur_done_reg[pc]  <= 1'b1;
                        prev_done_reg[ps] <= 1'b1;
                        slot_reg[pc] <= ps;
                        taken_reg <= taken_reg + idx_t'(1);
                    end
                    k_reg <= k_reg + pair_t'(1);
                end
                ST_FILL: begin
                    if (!cur_done_reg[i_reg]) begin
                        slot_reg[i_reg] <= taken_reg;
                        taken_reg <= taken_reg + idx_t'(1);
                    end
                    i_reg <= i_reg + idx_t'(1);
                end
                ST_GAP: begin
                    // Close the gap of a lifted touch, highest slot first
                    if (!prev_done_reg[g_reg - idx_t'(1)]) begin
                        for (int j = 0; j < MAX_FINGERS; j++)
                            if (j < int'(n_reg) && slot_reg[j] > g_reg - idx_t'(1))
                                slot_reg[j] <= slot_reg[j] - idx_t'(1);
                    end
                    g_reg <= g_reg - idx_t'(1);
                end
                ST_PLACE: begin
                    for (int j = 0; j < MAX_FINGERS; j++) begin
                        if (j < int'(n_reg) && slot_reg[j] < idx_t'(MAX_FINGERS)) begin
                            stored_reg[slot_reg[j]] <= raw_reg[j];
                            if (slot_reg[j] == idx_t'(n_reg - 1)) newest_pos_reg <= raw_reg[j];
                        end
                        if (j < int'(n_reg) && changed_reg && slot_reg[j] == idx_t'(n_reg - 1))
                            newest_idx_reg <= 4'(j);
                    end
                    prior_reg <= n_reg;
                end
                ST_DONE: begin
                    if (n_reg == '0) begin
                        newest_idx_reg <= 4'hF;
                        prior_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign stored_out     = stored_reg;
    assign newest_pos_out = newest_pos_reg;
    assign newest_idx_out = newest_idx_reg;
    assign n_out          = n_reg;
endmodule

>>> hw/rtl/multitouch_identity_tracker_unit.sv
`timescale 1ns / 1ps
// Top level of the multitouch identity tracker.
// One frame at a time: s_ready stays low from an input transfer until its result has
// been transferred, and the next frame can be taken the cycle after that. A frame with
// no touches goes straight to done, and a frame with an unchanged count goes straight
// to place and done. A changed count with p stored and n present touches (both non-zero)
// runs through one shared distance/compare unit: n*p pair builds, n*p sort steps plus
// one per swap (at most 190 swaps for 20 pairs), n*p match steps, then n fill or p gap
// steps, one place and one done step; from no stored touches it is n fill steps, then
// place and done. The result sits in an output register.
module multitouch_identity_tracker_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_touch_count,
    input  logic [15:0]         s_raw_pos0,
    input  logic [15:0]         s_raw_pos1,
    input  logic [15:0]         s_raw_pos2,
    input  logic [15:0]         s_raw_pos3,
    input  logic [15:0]         s_raw_pos4,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_active_count,
    output logic [15:0]         m_ordered_pos0,
    output logic [15:0]         m_ordered_pos1,
    output logic [15:0]         m_ordered_pos2,
    output logic [15:0]         m_ordered_pos3,
    output logic [15:0]         m_ordered_pos4,
    output logic [15:0]         m_newest_pos,
    output logic signed [3:0]   m_newest_raw_index
);
    import mtt_pkg::*;

    logic busy_reg;
    logic done;
    pos_t raw [MAX_FINGERS];
    pos_t stored [MAX_FINGERS];
    pos_t newest_pos;
    logic [3:0] newest_idx;
    cnt_t n_cur;
    pos_t ord_reg [MAX_FINGERS];

    assign raw[0] = s_raw_pos0;
    assign raw[1] = s_raw_pos1;
    assign raw[2] = s_raw_pos2;
    assign raw[3] = s_raw_pos3;
    assign raw[4] = s_raw_pos4;

    assign s_ready = !busy_reg && !m_valid;

    mtt_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (s_valid && s_ready),
        .n_in          (s_touch_count),
        .raw_in        (raw),
        .done          (done),
        .stored_out    (stored),
        .newest_pos_out(newest_pos),
        .newest_idx_out(newest_idx),
        .n_out         (n_cur)
    );

    // Hold busy from transfer to result, then present the result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            m_valid  <= 1'b0;
        end else begin
            if (s_valid && s_ready) busy_reg <= 1'b1;
            if (done) begin
                busy_reg <= 1'b0;
                m_valid  <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            m_active_count <= n_cur;
            for (int j = 0; j < MAX_FINGERS; j++)
                ord_reg[j] <= (j < int'(n_cur)) ? stored[j] : '0;
            m_newest_pos       <= newest_pos;
            m_newest_raw_index <= (n_cur == '0) ? -4'sd1 : signed'(newest_idx);
        end
    end

    assign m_ordered_pos0 = ord_reg[0];
    assign m_ordered_pos1 = ord_reg[1];
    assign m_ordered_pos2 = ord_reg[2];
    assign m_ordered_pos3 = ord_reg[3];
    assign m_ordered_pos4 = ord_reg[4];
endmodule

>>> hw/rtl/mtt_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the tracker, bound to the top level.
module mtt_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [2:0]        m_active_count,
    input logic [15:0]       m_ordered_pos4,
    input logic signed [3:0] m_newest_raw_index
);
    // No new transfer while a result waits
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");

    // Result held until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_active_count))
        else $error("result dropped");

    // No touches means index minus one
    a_none: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_active_count == 3'd0 |-> m_newest_raw_index == -4'sd1)
        else $error("bad index for no touches");

    // Count never above five
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_active_count <= 3'd5) else $error("count out of range");

    // Last position cleared unless all five touches are tracked
    a_pos4: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_active_count < 3'd5 |-> m_ordered_pos4 == 16'h0000)
        else $error("unused position not cleared");
endmodule

bind multitouch_identity_tracker_unit mtt_checker u_mtt_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_active_count    (m_active_count),
    .m_ordered_pos4    (m_ordered_pos4),
    .m_newest_raw_index(m_newest_raw_index)
);
